// ===== hdl/bfa_pkg.sv =====
// shared constants, types and codes for the best-fit boundary-tag allocator
// no dependencies; imported by every other file of the block but bfa_ram
`default_nettype none

package bfa_pkg;

    // default heap geometry
    localparam int unsigned HEAP_WORDS_DEF        = 4096;
    localparam int unsigned HEADER_WORDS_DEF      = 3;
    localparam int unsigned META_WORDS_DEF        = 4;
    localparam int unsigned DATA_OFFSET_BYTES_DEF = 12;

    // fixed field widths
    localparam int unsigned OFS_W  = 14;
    localparam int unsigned SIZE_W = 32;
    // byte address width, wide enough that no in-range sum wraps back into the heap
    localparam int unsigned ADDR_W = 36;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // one access from the sequencer to the heap memory
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] wdata;
    } mem_req_t;

    // one finished result
    typedef struct packed {
        logic             ok;
        logic [OFS_W-1:0] data_offset;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/bfa_in_if.sv =====
// request channel: operation, byte count and offset with valid/ready
// depends on bfa_pkg
`default_nettype none

interface bfa_in_if
    import bfa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             func;
    logic [OFS_W-1:0] request_bytes;
    logic [OFS_W-1:0] block_offset;

    modport source (output valid, func, request_bytes, block_offset, input ready);
    modport sink   (input valid, func, request_bytes, block_offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/bfa_out_if.sv =====
// response channel: status and data offset with valid/ready
// depends on bfa_pkg
`default_nettype none

interface bfa_out_if
    import bfa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [OFS_W-1:0] data_offset;

    modport source (output valid, ok, data_offset, input ready);
    modport sink   (input valid, ok, data_offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/best_fit_boundary_tag_allocator.sv =====
// Best-fit heap allocator with boundary tags. The heap lies in one single-port
// synchronous RAM of HEAP_WORDS words; every access goes through that one port,
// so the time per request is set by the number of reads and writes it needs.
// An allocate is accepted, walks the block list from the start reading the
// flag and then the size of each block, chooses, and presents the response;
// when the chosen block is split it first writes three tags for the taken
// part, makes one check, and writes three tags for the remainder. At most
// HEAP_WORDS/META_WORDS blocks are visited. A free with an offset below the
// data offset or beyond the heap is answered without touching the memory;
// otherwise its work depends on which neighbours exist and how many merge.
// The response waits until the output register can take it.
// After reset a clearing pass over every heap word builds the initial free
// block; no request is taken until it ends. One request is worked at a time;
// a new one is taken while the previous response still waits in the output
// register.
// depends on bfa_pkg, bfa_in_if, bfa_out_if, bfa_ctrl, bfa_mport
`default_nettype none

module best_fit_boundary_tag_allocator
    import bfa_pkg::*;
#(
    parameter int unsigned HEAP_WORDS        = HEAP_WORDS_DEF,
    parameter int unsigned HEADER_WORDS      = HEADER_WORDS_DEF,
    parameter int unsigned META_WORDS        = META_WORDS_DEF,
    parameter int unsigned DATA_OFFSET_BYTES = DATA_OFFSET_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bfa_in_if.sink    req,
    bfa_out_if.source rsp
);
    mem_req_t          mreq;
    logic [SIZE_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg, out_res_next;

    bfa_ctrl #(
        .HEAP_WORDS        (HEAP_WORDS),
        .HEADER_WORDS      (HEADER_WORDS),
        .META_WORDS        (META_WORDS),
        .DATA_OFFSET_BYTES (DATA_OFFSET_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    bfa_mport #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_mport (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .rdata (rdata)
    );

    // output register, filled when empty or once the held transfer is taken
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_res_reg.ok;
    assign rsp.data_offset = out_res_reg.data_offset;
endmodule

`default_nettype wire

// ===== hdl/bfa_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module bfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

`default_nettype wire

// ===== hdl/bfa_mport.sv =====
// byte-address front end of the heap memory: range check, word select, zero fill
// depends on bfa_pkg and bfa_ram
`default_nettype none

module bfa_mport
    import bfa_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mem_req_t          mreq,
    output logic      [SIZE_W-1:0] rdata
);
    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam logic [ADDR_W-1:0] HEAP_B = ADDR_W'(HEAP_WORDS * 4);

    logic              in_range;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic [SIZE_W-1:0] q;

    // words outside the heap read as zero and drop writes
    assign in_range   = mreq.addr < HEAP_B;
    assign rd_ok_next = mreq.rd && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_ok_next;
        end
    end

    bfa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mreq.wr && in_range),
        .addr  (mreq.addr[AW+1:2]),
        .wdata (mreq.wdata),
        .rdata (q)
    );

    assign rdata = rd_ok_reg ? q : '0;
endmodule

`default_nettype wire

// ===== hdl/bfa_ctrl.sv =====
// sequencer: clearing pass, best-fit walk, split, free with coalescing
// depends on bfa_pkg and bfa_in_if
`default_nettype none

module bfa_ctrl
    import bfa_pkg::*;
#(
    parameter int unsigned HEAP_WORDS        = HEAP_WORDS_DEF,
    parameter int unsigned HEADER_WORDS      = HEADER_WORDS_DEF,
    parameter int unsigned META_WORDS        = META_WORDS_DEF,
    parameter int unsigned DATA_OFFSET_BYTES = DATA_OFFSET_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bfa_in_if.sink                 req,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res,
    output mem_req_t               mreq,
    input  wire logic [SIZE_W-1:0] rdata
);
    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam int unsigned WANT_W = OFS_W + 1;
    localparam logic [ADDR_W-1:0] HEAP_B = ADDR_W'(HEAP_WORDS * 4);
    localparam logic [ADDR_W-1:0] HDR_B  = ADDR_W'(HEADER_WORDS * 4);
    localparam logic [ADDR_W-1:0] META_B = ADDR_W'(META_WORDS * 4);
    localparam logic [ADDR_W-1:0] FTR_B  = ADDR_W'((META_WORDS - HEADER_WORDS) * 4);
    localparam logic [ADDR_W-1:0] DOB    = ADDR_W'(DATA_OFFSET_BYTES);
    localparam logic [ADDR_W-1:0] SZ_OFS = ADDR_W'(4);
    localparam logic [SIZE_W-1:0] META_S = SIZE_W'(META_WORDS * 4);
    localparam logic [SIZE_W-1:0] INIT_S = SIZE_W'(HEAP_WORDS * 4 - META_WORDS * 4);
    localparam logic [AW-1:0] LAST_W = AW'(HEAP_WORDS - 1);
    localparam logic [AW-1:0] FTR_W  = AW'(HEAP_WORDS + HEADER_WORDS - META_WORDS);

    // sequencer states
    localparam logic [4:0] ST_CLEAR   = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_A_FLAG  = 5'd2;
    localparam logic [4:0] ST_A_SIZE  = 5'd3;
    localparam logic [4:0] ST_A_END   = 5'd4;
    localparam logic [4:0] ST_A_SPLIT = 5'd5;
    localparam logic [4:0] ST_F_MARK  = 5'd6;
    localparam logic [4:0] ST_F_RSB   = 5'd7;
    localparam logic [4:0] ST_F_NXT   = 5'd8;
    localparam logic [4:0] ST_F_FTR   = 5'd9;
    localparam logic [4:0] ST_F_CHKN  = 5'd10;
    localparam logic [4:0] ST_F_NFLAG = 5'd11;
    localparam logic [4:0] ST_F_J1A   = 5'd12;
    localparam logic [4:0] ST_F_J1B   = 5'd13;
    localparam logic [4:0] ST_F_CHKP  = 5'd14;
    localparam logic [4:0] ST_F_PFLAG = 5'd15;
    localparam logic [4:0] ST_F_J2A   = 5'd16;
    localparam logic [4:0] ST_F_J2B   = 5'd17;
    localparam logic [4:0] ST_PUT0    = 5'd18;
    localparam logic [4:0] ST_PUT1    = 5'd19;
    localparam logic [4:0] ST_PUT2    = 5'd20;
    localparam logic [4:0] ST_DONE    = 5'd21;

    // where to continue after a block write
    localparam logic [1:0] RET_SPLIT = 2'd0;
    localparam logic [1:0] RET_CHKP  = 2'd1;
    localparam logic [1:0] RET_OK    = 2'd2;

    logic [4:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic              have_reg, have_next;
    logic              flag_reg, flag_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;
    logic [ADDR_W-1:0] prv_reg, prv_next;
    logic              has_next_reg, has_next_next;
    logic              has_prev_reg, has_prev_next;
    logic [SIZE_W-1:0] s1_reg, s1_next;
    logic [ADDR_W-1:0] put_base_reg, put_base_next;
    logic              put_flag_reg, put_flag_next;
    logic [SIZE_W-1:0] put_size_reg, put_size_next;
    logic [1:0]        ret_reg, ret_next;
    logic              res_ok_reg, res_ok_next;
    logic [OFS_W-1:0]  res_ofs_reg, res_ofs_next;

    logic [SIZE_W-1:0] want_s;
    logic [ADDR_W-1:0] rd_ext;
    logic [ADDR_W-1:0] ofs_ext;
    logic              hit;
    logic              take;
    logic [SIZE_W-1:0] nb_size;
    logic [ADDR_W-1:0] walk_nxt;
    logic [ADDR_W-1:0] split_nxt;
    logic [ADDR_W-1:0] best_ofs;

    assign want_s    = SIZE_W'(want_reg);
    assign rd_ext    = ADDR_W'(rdata);
    assign ofs_ext   = ADDR_W'(req.block_offset);
    assign hit       = flag_reg && (rdata >= want_s);
    assign take      = hit && (!have_reg || (rdata < best_size_reg));
    assign nb_size   = take ? rdata : best_size_reg;
    assign walk_nxt  = cur_reg + META_B + rd_ext;
    assign split_nxt = best_reg + META_B + ADDR_W'(want_reg);
    assign best_ofs  = best_reg + DOB;

    assign req.ready       = state_reg == ST_IDLE;
    assign res_valid       = state_reg == ST_DONE;
    assign res.ok          = res_ok_reg;
    assign res.data_offset = res_ofs_reg;

    // next-state and memory access logic
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        have_next      = have_reg;
        flag_next      = flag_reg;
        want_next      = want_reg;
        blk_next       = blk_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        has_next_next  = has_next_reg;
        has_prev_next  = has_prev_reg;
        s1_next        = s1_reg;
        put_base_next  = put_base_reg;
        put_flag_next  = put_flag_reg;
        put_size_next  = put_size_reg;
        ret_next       = ret_reg;
        res_ok_next    = res_ok_reg;
        res_ofs_next   = res_ofs_reg;
        mreq           = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // zero the heap and lay down one free block spanning it
                mreq.wr   = 1'b1;
                mreq.addr = ADDR_W'({clr_reg, 2'b00});
                if (clr_reg == FTR_W || clr_reg == AW'(1))
                begin
                    mreq.wdata = INIT_S;
                end
                else if (clr_reg == '0)
                begin
                    mreq.wdata = SIZE_W'(1);
                end
                else
                begin
                    mreq.wdata = '0;
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_W)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_ALLOC)
                    begin
                        want_next  = (WANT_W'(req.request_bytes) + WANT_W'(3))
                                     & ~WANT_W'(3);
                        cur_next   = '0;
                        have_next  = 1'b0;
                        mreq.rd    = 1'b1;
                        mreq.addr  = '0;
                        state_next = ST_A_FLAG;
                    end
                    else
                    begin
                        res_ofs_next = '0;
                        if (ofs_ext < DOB || (ofs_ext - DOB) >= HEAP_B)
                        begin
                            res_ok_next = 1'b0;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            res_ok_next = 1'b1;
                            blk_next    = ofs_ext - DOB;
                            state_next  = ST_F_MARK;
                        end
                    end
                end
            end
            ST_A_FLAG:
            begin
                flag_next  = rdata != '0;
                mreq.rd    = 1'b1;
                mreq.addr  = cur_reg + SZ_OFS;
                state_next = ST_A_SIZE;
            end
            ST_A_SIZE:
            begin
                // keep the smallest fit, stop on an exact fit or the heap end
                if (take)
                begin
                    have_next      = 1'b1;
                    best_next      = cur_reg;
                    best_size_next = rdata;
                end
                if (!(hit && nb_size == want_s) && walk_nxt < HEAP_B)
                begin
                    cur_next   = walk_nxt;
                    mreq.rd    = 1'b1;
                    mreq.addr  = walk_nxt;
                    state_next = ST_A_FLAG;
                end
                else
                begin
                    state_next = ST_A_END;
                end
            end
            ST_A_END:
            begin
                res_ok_next  = have_reg;
                res_ofs_next = have_reg ? best_ofs[OFS_W-1:0] : '0;
                if (!have_reg)
                begin
                    state_next = ST_DONE;
                end
                else if ((want_s + META_S) < best_size_reg)
                begin
                    put_base_next = best_reg;
                    put_flag_next = 1'b0;
                    put_size_next = want_s;
                    ret_next      = RET_SPLIT;
                    state_next    = ST_PUT0;
                end
                else
                begin
                    mreq.wr    = 1'b1;
                    mreq.addr  = best_reg;
                    mreq.wdata = '0;
                    state_next = ST_DONE;
                end
            end
            ST_A_SPLIT:
            begin
                // remainder becomes a free block after the taken one
                if (split_nxt < HEAP_B)
                begin
                    put_base_next = split_nxt;
                    put_flag_next = 1'b1;
                    put_size_next = best_size_reg - META_S - want_s;
                    ret_next      = RET_OK;
                    state_next    = ST_PUT0;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_MARK:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = blk_reg;
                mreq.wdata = SIZE_W'(1);
                state_next = ST_F_RSB;
            end
            ST_F_RSB:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = blk_reg + SZ_OFS;
                state_next = ST_F_NXT;
            end
            ST_F_NXT:
            begin
                nxt_next      = blk_reg + META_B + rd_ext;
                has_next_next = (blk_reg + META_B + rd_ext) < HEAP_B;
                if (blk_reg != '0)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = blk_reg - FTR_B;
                    state_next = ST_F_FTR;
                end
                else
                begin
                    has_prev_next = 1'b0;
                    state_next    = ST_F_CHKN;
                end
            end
            ST_F_FTR:
            begin
                prv_next      = blk_reg - FTR_B - rd_ext - HDR_B;
                has_prev_next = 1'b1;
                state_next    = ST_F_CHKN;
            end
            ST_F_CHKN:
            begin
                if (has_next_reg)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = nxt_reg;
                    state_next = ST_F_NFLAG;
                end
                else
                begin
                    state_next = ST_F_CHKP;
                end
            end
            ST_F_NFLAG:
            begin
                if (rdata != '0)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = blk_reg + SZ_OFS;
                    state_next = ST_F_J1A;
                end
                else
                begin
                    state_next = ST_F_CHKP;
                end
            end
            ST_F_J1A:
            begin
                s1_next    = rdata;
                mreq.rd    = 1'b1;
                mreq.addr  = nxt_reg + SZ_OFS;
                state_next = ST_F_J1B;
            end
            ST_F_J1B:
            begin
                put_base_next = blk_reg;
                put_flag_next = 1'b1;
                put_size_next = s1_reg + rdata + META_S;
                ret_next      = RET_CHKP;
                state_next    = ST_PUT0;
            end
            ST_F_CHKP:
            begin
                if (has_prev_reg)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = prv_reg;
                    state_next = ST_F_PFLAG;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_PFLAG:
            begin
                if (rdata != '0)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = prv_reg + SZ_OFS;
                    state_next = ST_F_J2A;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_J2A:
            begin
                s1_next    = rdata;
                mreq.rd    = 1'b1;
                mreq.addr  = blk_reg + SZ_OFS;
                state_next = ST_F_J2B;
            end
            ST_F_J2B:
            begin
                put_base_next = prv_reg;
                put_flag_next = 1'b1;
                put_size_next = s1_reg + rdata + META_S;
                ret_next      = RET_OK;
                state_next    = ST_PUT0;
            end
            ST_PUT0:
            begin
                // header flag word
                mreq.wr    = 1'b1;
                mreq.addr  = put_base_reg;
                mreq.wdata = SIZE_W'(put_flag_reg);
                state_next = ST_PUT1;
            end
            ST_PUT1:
            begin
                // header size word
                mreq.wr    = 1'b1;
                mreq.addr  = put_base_reg + SZ_OFS;
                mreq.wdata = put_size_reg;
                state_next = ST_PUT2;
            end
            ST_PUT2:
            begin
                // footer size word
                mreq.wr    = 1'b1;
                mreq.addr  = put_base_reg + HDR_B + ADDR_W'(put_size_reg);
                mreq.wdata = put_size_reg;
                case (ret_reg)
                    RET_SPLIT: state_next = ST_A_SPLIT;
                    RET_CHKP:  state_next = ST_F_CHKP;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        have_reg      <= have_next;
        flag_reg      <= flag_next;
        want_reg      <= want_next;
        blk_reg       <= blk_next;
        nxt_reg       <= nxt_next;
        prv_reg       <= prv_next;
        has_next_reg  <= has_next_next;
        has_prev_reg  <= has_prev_next;
        s1_reg        <= s1_next;
        put_base_reg  <= put_base_next;
        put_flag_reg  <= put_flag_next;
        put_size_reg  <= put_size_next;
        ret_reg       <= ret_next;
        res_ok_reg    <= res_ok_next;
        res_ofs_reg   <= res_ofs_next;
    end
endmodule

`default_nettype wire

// ===== tb/tb_best_fit_boundary_tag_allocator.sv =====
// self-checking testbench for the best-fit boundary-tag allocator
// depends on bfa_pkg, bfa_in_if, bfa_out_if and best_fit_boundary_tag_allocator
`default_nettype none

module tb_best_fit_boundary_tag_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int unsigned NWORDS   = HEAP_WORDS_DEF;
    localparam longint unsigned HEAP_B = longint'(NWORDS) * 4;
    localparam longint unsigned HDR_B  = longint'(HEADER_WORDS_DEF) * 4;
    localparam longint unsigned META_B = longint'(META_WORDS_DEF) * 4;
    localparam longint unsigned FTR_B  = META_B - HDR_B;
    localparam longint unsigned DOFS_B = DATA_OFFSET_BYTES_DEF;
    localparam int unsigned STALL_LIMIT = 40000;

    typedef struct {
        logic             func;
        logic [OFS_W-1:0] nbytes;
        logic [OFS_W-1:0] ofs;
        bit               typed;
        result_t          known;
    } heap_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfa_in_if  req ();
    bfa_out_if rsp ();

    best_fit_boundary_tag_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #5 clk = ~clk;

    // shadow heap and pending results
    logic [31:0] shadow_heap [NWORDS];
    result_t     pending_rsp [$];
    int          live_ofs [$];
    int          n_errors = 0;
    int          n_rsp = 0;
    int          quiet_cycles = 0;

    function automatic logic [31:0] heap_rd(longint unsigned addr);
        longint unsigned w = addr >> 2;
        return (w < NWORDS) ? shadow_heap[w] : 32'd0;
    endfunction

    function automatic void heap_wr(longint unsigned addr, logic [31:0] v);
        longint unsigned w = addr >> 2;
        if (w < NWORDS)
            shadow_heap[w] = v;
    endfunction

    function automatic void write_tags(longint unsigned blk, logic [31:0] flag,
                                       logic [31:0] size);
        heap_wr(blk, flag);
        heap_wr(blk + 4, size);
        heap_wr(blk + HDR_B + longint'(size), size);
    endfunction

    function automatic void heap_clear();
        foreach (shadow_heap[i])
            shadow_heap[i] = '0;
        write_tags(0, 32'd1, 32'(HEAP_B - META_B));
    endfunction

    function automatic void join_tags(longint unsigned first, longint unsigned second);
        logic [31:0] s = heap_rd(first + 4) + heap_rd(second + 4) + 32'(META_B);
        write_tags(first, 32'd1, s);
    endfunction

    // best-fit search, split or take whole
    function automatic result_t heap_alloc(logic [OFS_W-1:0] nbytes);
        logic [31:0] want = 32'((longint'(nbytes) + 3) & ~longint'(3));
        longint unsigned cur = 0, best = 0, nxt;
        bit have = 0;
        logic [31:0] best_size = 0, sz;
        result_t r;
        forever
        begin
            if (heap_rd(cur) != 0)
            begin
                sz = heap_rd(cur + 4);
                if (sz >= want)
                begin
                    if (!have || sz < best_size)
                    begin
                        have = 1;
                        best = cur;
                        best_size = sz;
                    end
                    if (best_size == want)
                        break;
                end
            end
            nxt = cur + META_B + longint'(heap_rd(cur + 4));
            if (nxt >= HEAP_B)
                break;
            cur = nxt;
        end
        if (!have)
            return '{ok: 1'b0, data_offset: '0};
        if (longint'(want) + META_B < longint'(best_size))
        begin
            write_tags(best, 32'd0, want);
            nxt = best + META_B + longint'(heap_rd(best + 4));
            if (nxt < HEAP_B)
                write_tags(nxt, 32'd1, 32'(longint'(best_size) - META_B - longint'(want)));
        end
        else
            heap_wr(best, 32'd0);
        r.ok = 1'b1;
        r.data_offset = OFS_W'(best + DOFS_B);
        return r;
    endfunction

    // mark free and merge with next, then previous neighbour
    function automatic result_t heap_free(logic [OFS_W-1:0] ofs);
        longint unsigned blk, nxt, prv, ftr;
        bit has_next, has_prev;
        if (longint'(ofs) < DOFS_B)
            return '{ok: 1'b0, data_offset: '0};
        blk = longint'(ofs) - DOFS_B;
        heap_wr(blk, 32'd1);
        nxt = blk + META_B + longint'(heap_rd(blk + 4));
        has_next = nxt < HEAP_B;
        has_prev = blk != 0;
        if (has_prev)
        begin
            ftr = blk - FTR_B;
            prv = ftr - longint'(heap_rd(ftr)) - HDR_B;
        end
        if (has_next && heap_rd(nxt) != 0)
            join_tags(blk, nxt);
        if (has_prev && heap_rd(prv) != 0)
            join_tags(prv, blk);
        return '{ok: 1'b1, data_offset: '0};
    endfunction

    // offer one transfer and record its expected result once accepted
    task automatic issue(heap_op_t op);
        result_t r;
        req.valid         <= 1'b1;
        req.func          <= op.func;
        req.request_bytes <= op.nbytes;
        req.block_offset  <= op.ofs;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = (op.func == FUNC_ALLOC) ? heap_alloc(op.nbytes) : heap_free(op.ofs);
        if (op.func == FUNC_ALLOC && r.ok)
            live_ofs.push_back(int'(r.data_offset));
        pending_rsp.push_back(op.typed ? op.known : r);
    endtask

    task automatic gap(int n);
        req.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic heap_op_t mk(logic f, int nb, int of);
        heap_op_t op;
        op.func = f;
        op.nbytes = OFS_W'(nb);
        op.ofs = OFS_W'(of);
        op.typed = 0;
        op.known = '0;
        return op;
    endfunction

    function automatic heap_op_t mk_known(logic f, int nb, int of, logic k, int d);
        heap_op_t op = mk(f, nb, of);
        op.typed = 1;
        op.known = '{ok: k, data_offset: OFS_W'(d)};
        return op;
    endfunction

    // stimulus and end of run
    initial
    begin
        heap_op_t plan [$];
        heap_op_t op;
        int idx, n_sent;
        req.valid <= 1'b0;
        req.func <= FUNC_ALLOC;
        req.request_bytes <= '0;
        req.block_offset <= '0;
        heap_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: split, fail, bad offsets, exact fit, merges, whole take
        plan.push_back(mk_known(FUNC_ALLOC, 0, 0, 1'b1, 12));
        plan.push_back(mk_known(FUNC_ALLOC, 16383, 0, 1'b0, 0));
        plan.push_back(mk_known(FUNC_FREE, 0, 0, 1'b0, 0));
        plan.push_back(mk_known(FUNC_FREE, 0, 11, 1'b0, 0));
        plan.push_back(mk_known(FUNC_ALLOC, 5, 0, 1'b1, 28));
        plan.push_back(mk(FUNC_ALLOC, 100, 0));
        plan.push_back(mk(FUNC_FREE, 0, 28));
        plan.push_back(mk(FUNC_ALLOC, 8, 0));
        plan.push_back(mk(FUNC_FREE, 0, 52));
        plan.push_back(mk(FUNC_FREE, 0, 28));
        plan.push_back(mk(FUNC_FREE, 0, 12));
        plan.push_back(mk(FUNC_ALLOC, 16368, 0));
        plan.push_back(mk(FUNC_FREE, 16383, 12));
        plan.push_back(mk(FUNC_ALLOC, 16357, 0));
        plan.push_back(mk(FUNC_FREE, 0, 12));
        plan.push_back(mk(FUNC_ALLOC, 3, 0));
        plan.push_back(mk(FUNC_ALLOC, 4, 0));
        plan.push_back(mk(FUNC_FREE, 0, 12));
        plan.push_back(mk(FUNC_FREE, 0, 28));
        foreach (plan[i])
            issue(plan[i]);

        // sender holds off until the block has drained
        gap(1);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        live_ofs.delete();
        op = mk(FUNC_FREE, 0, 12);
        issue(op);

        // random: frees of live blocks and mixed-size allocations, allocations the more frequent
        for (n_sent = 0; n_sent < 140; n_sent++)
        begin
            if (live_ofs.size() != 0 && $urandom_range(99) < 45)
            begin
                idx = $urandom_range(live_ofs.size() - 1);
                op = mk(FUNC_FREE, $urandom, live_ofs[idx]);
                live_ofs.delete(idx);
            end
            else
            begin
                case ($urandom_range(19))
                    0:       op = mk(FUNC_ALLOC, $urandom_range(16383), $urandom);
                    1, 2, 3: op = mk(FUNC_ALLOC, $urandom_range(2000), $urandom);
                    default: op = mk(FUNC_ALLOC, $urandom_range(200), $urandom);
                endcase
            end
            // stray offsets at the tail, on a heap already exercised
            if (n_sent >= 136)
                op = mk(FUNC_FREE, $urandom, $urandom);
            issue(op);
            if ((n_sent < 60 || n_sent >= 90) && $urandom_range(99) < 30)
                gap($urandom_range(1, 4));
        end
        gap(1);

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (n_errors == 0)
            $display("tb_best_fit_boundary_tag_allocator OK");
        else
            $display("tb_best_fit_boundary_tag_allocator NOT OK");
        $finish;
    end

    // result side: random back-pressure, one long hold, a run with ready held high, field checks
    initial
    begin
        result_t exp_r;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                n_rsp++;
                if (pending_rsp.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result ok=%0b ofs=%0d", rsp.ok, rsp.data_offset);
                end
                else
                begin
                    exp_r = pending_rsp.pop_front();
                    if (rsp.ok !== exp_r.ok || rsp.data_offset !== exp_r.data_offset)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: expected ok=%0b ofs=%0d, got ok=%0b ofs=%0d",
                                     n_rsp, exp_r.ok, exp_r.data_offset,
                                     rsp.ok, rsp.data_offset);
                    end
                end
                if (n_rsp == 40)
                begin
                    rsp.ready <= 1'b0;
                    repeat (300) @(posedge clk);
                end
            end
            if (n_rsp >= 80 && n_rsp < 110)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) >= 30);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_best_fit_boundary_tag_allocator NOT OK");
            $finish;
        end
    end

endmodule

`default_nettype wire
